// ===== rtl/upsc_pkg.sv =====
// upsc_pkg: shared widths, register indexes and row selection type for the
// 2x bilinear upscaler. No dependencies.
package upsc_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned COL_W      = 7;
  localparam int unsigned RCNT_W     = 12;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;

  localparam logic [COL_W-1:0] WIDTH_RESET  = 7'd64;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 13'd64;

  typedef enum logic [1:0] {
    ROW_ABOVE = 2'd0,
    ROW_MID   = 2'd1,
    ROW_BELOW = 2'd2
  } rsel_e;

endpackage

// ===== rtl/upsc_pix_if.sv =====
// upsc_pix_if: source pixel request channel (valid, ready, pixel_in).
// Depends on upsc_pkg.
interface upsc_pix_if import upsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== rtl/upsc_res_if.sv =====
// upsc_res_if: output pixel request channel with coordinates and run flags.
// Depends on upsc_pkg.
interface upsc_res_if import upsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [PIX_W-1:0] pixel_out;
  logic             run_last;
  logic             frame_done;

  modport source (output valid, output out_row, output out_col, output pixel_out,
                  output run_last, output frame_done, input ready);
  modport sink   (input valid, input out_row, input out_col, input pixel_out,
                  input run_last, input frame_done, output ready);
endinterface

// ===== rtl/bilinear_2x_upscaler.sv =====
// bilinear_2x_upscaler: 2x bilinear upscaler with a one-row line store.
// Depends on upsc_pkg, upsc_pix_if, upsc_res_if.
// The first result of a request passes the stage 1, sequencer and output registers.
// Throughput: one result per cycle from the output register while dst.ready is
// high; interior requests give 4 results, last column 8, last pixel 12.
// Reset: asynchronous, active low; clears counters, neighbours and flags.
// The line store is not cleared.
module bilinear_2x_upscaler import upsc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  upsc_pix_if.sink              src,
  upsc_res_if.source            dst
);

  localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CFW = (CW + 2 > COL_W) ? CW + 2 : COL_W;

  logic [PIX_W-1:0] row_store [MAX_WIDTH];

  logic [COL_W-1:0]  width_q, width_d;
  logic [ROW_W-1:0]  height_q, height_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RCNT_W-1:0] row_q, row_d;
  logic [PIX_W-1:0]  left_q, left_d, uleft_q, uleft_d;

  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             last_col, last_row;

  logic              s1_vld_q, s1_vld_d;
  logic [PIX_W-1:0]  s1_pix_q, rd_q;
  logic [CW-1:0]     s1_col_q;
  logic [RCNT_W-1:0] s1_row_q;
  logic              s1_lcol_q, s1_lrow_q;
  logic [PIX_W-1:0]  s1_up;

  logic              j_vld_q, j_vld_d;
  logic [PIX_W-1:0]  j_p_q, j_l_q, j_ul_q, j_up_q;
  logic [CW-1:0]     j_col_q;
  logic [RCNT_W-1:0] j_row_q;
  logic              j_lcol_q, j_lrow_q;
  rsel_e             rsel_q, rsel_d, rlast;
  logic [1:0]        csel_q, csel_d, clast;

  logic             o_vld_q, o_vld_d;
  logic [ROW_W-1:0] o_row_q;
  logic [COL_W-1:0] o_col_q;
  logic [PIX_W-1:0] o_pix_q;
  logic             o_last_q, o_done_q;

  logic accept, s1_go, j_load, emit, at_last, j_fin;
  logic [PIX_W+1:0] sum_h, sum_v, sum_hv, sum4;
  logic [PIX_W-1:0] val;
  logic [ROW_W-1:0] row_base, row_val;
  logic [CFW-1:0]   col_full;

  // effective frame size
  always_comb begin
    if (width_q < 7'd2) begin
      w_eff = 7'd2;
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q < 13'd2) begin
      h_eff = 13'd2;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    last_col = (32'(col_q) + 32'd1) >= 32'(w_eff);
    last_row = (32'(row_q) + 32'd1) >= 32'(h_eff);
  end

  // handshake and stage movement
  assign emit     = j_vld_q && (!o_vld_q || dst.ready);
  assign at_last  = (rsel_q == rlast) && (csel_q == clast);
  assign j_fin    = emit && at_last;
  assign s1_go    = s1_vld_q && ((s1_col_q == '0) || !j_vld_q || j_fin);
  assign j_load   = s1_go && (s1_col_q != '0);
  assign src.ready = !s1_vld_q || s1_go;
  assign accept   = src.valid && src.ready;
  assign s1_up    = (s1_row_q != '0) ? rd_q : '0;

  // frame counters and configuration
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i && (cfg_idx_i == CFG_SOURCE_WIDTH)) begin
      width_d = cfg_data_i[COL_W-1:0];
      col_d   = '0;
      row_d   = '0;
    end else if (cfg_we_i && (cfg_idx_i == CFG_SOURCE_HEIGHT)) begin
      height_d = cfg_data_i;
      col_d    = '0;
      row_d    = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // neighbour registers follow stage 1 in order
  always_comb begin
    left_d  = left_q;
    uleft_d = uleft_q;
    if (s1_go) begin
      left_d  = s1_pix_q;
      uleft_d = s1_up;
    end
  end

  always_comb begin
    s1_vld_d = accept ? 1'b1 : (s1_go ? 1'b0 : s1_vld_q);
    j_vld_d  = j_load ? 1'b1 : (j_fin ? 1'b0 : j_vld_q);
    o_vld_d  = emit ? 1'b1 : (dst.ready ? 1'b0 : o_vld_q);
  end

  // result sequencer
  always_comb begin
    rlast = j_lrow_q ? ROW_BELOW : ROW_MID;
    clast = j_lcol_q ? 2'd3 : 2'd1;
    rsel_d = rsel_q;
    csel_d = csel_q;
    if (j_load) begin
      rsel_d = (s1_row_q != '0) ? ROW_ABOVE : ROW_MID;
      csel_d = 2'd0;
    end else if (emit && !at_last) begin
      if (csel_q == clast) begin
        csel_d = 2'd0;
        unique case (rsel_q)
          ROW_ABOVE: rsel_d = ROW_MID;
          default:   rsel_d = ROW_BELOW;
        endcase
      end else begin
        csel_d = csel_q + 2'd1;
      end
    end
  end

  always_comb begin
    sum_h  = {2'b00, j_l_q} + {2'b00, j_p_q};
    sum_v  = {2'b00, j_ul_q} + {2'b00, j_l_q};
    sum_hv = {2'b00, j_up_q} + {2'b00, j_p_q};
    sum4   = sum_v + sum_hv;
    unique case (rsel_q)
      ROW_ABOVE: begin
        unique case (csel_q)
          2'd0:    val = sum_v[PIX_W:1];
          2'd1:    val = sum4[PIX_W+1:2];
          default: val = sum_hv[PIX_W:1];
        endcase
      end
      default: begin
        unique case (csel_q)
          2'd0:    val = j_l_q;
          2'd1:    val = sum_h[PIX_W:1];
          default: val = j_p_q;
        endcase
      end
    endcase
    row_base = {j_row_q, 1'b0};
    unique case (rsel_q)
      ROW_ABOVE: row_val = row_base - 1'b1;
      ROW_MID:   row_val = row_base;
      default:   row_val = row_base | 13'd1;
    endcase
    col_full = CFW'({j_col_q, 1'b0}) - CFW'(2) + CFW'(csel_q);
  end

  // line store: read-first, one read and one write per request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q                <= row_store[col_q];
      row_store[col_q]    <= src.pixel_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= src.pixel_in;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_lcol_q <= last_col;
      s1_lrow_q <= last_row;
    end
    if (j_load) begin
      j_p_q    <= s1_pix_q;
      j_l_q    <= left_q;
      j_ul_q   <= uleft_q;
      j_up_q   <= s1_up;
      j_col_q  <= s1_col_q;
      j_row_q  <= s1_row_q;
      j_lcol_q <= s1_lcol_q;
      j_lrow_q <= s1_lrow_q;
    end
    if (emit) begin
      o_row_q  <= row_val;
      o_col_q  <= col_full[COL_W-1:0];
      o_pix_q  <= val;
      o_last_q <= at_last;
      o_done_q <= at_last && j_lcol_q && j_lrow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      uleft_q  <= '0;
      s1_vld_q <= 1'b0;
      j_vld_q  <= 1'b0;
      o_vld_q  <= 1'b0;
      rsel_q   <= ROW_MID;
      csel_q   <= 2'd0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      left_q   <= left_d;
      uleft_q  <= uleft_d;
      s1_vld_q <= s1_vld_d;
      j_vld_q  <= j_vld_d;
      o_vld_q  <= o_vld_d;
      rsel_q   <= rsel_d;
      csel_q   <= csel_d;
    end
  end

  assign dst.valid      = o_vld_q;
  assign dst.out_row    = o_row_q;
  assign dst.out_col    = o_col_q;
  assign dst.pixel_out  = o_pix_q;
  assign dst.run_last   = o_last_q;
  assign dst.frame_done = o_done_q;

endmodule

// ===== rtl/upsc_checker.sv =====
// upsc_checker: port-level assertions for bilinear_2x_upscaler, with bind.
// Depends on upsc_pkg.
module upsc_checker import upsc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ROW_W-1:0] out_row_i,
  input logic [COL_W-1:0] out_col_i,
  input logic [PIX_W-1:0] pixel_out_i,
  input logic             run_last_i,
  input logic             frame_done_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_row_i) &&
    $stable(out_col_i) && $stable(pixel_out_i) && $stable(run_last_i))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> run_last_i)
    else $error("frame end without run end");

  a_done_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> out_row_i[0] && out_col_i[0])
    else $error("frame end not on odd corner");

  a_run_odd_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && run_last_i |-> out_col_i[0])
    else $error("run end on even column");

endmodule

bind bilinear_2x_upscaler upsc_checker u_upsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (dst.valid),
  .out_ready_i  (dst.ready),
  .out_row_i    (dst.out_row),
  .out_col_i    (dst.out_col),
  .pixel_out_i  (dst.pixel_out),
  .run_last_i   (dst.run_last),
  .frame_done_i (dst.frame_done)
);
